// ----- hw/rtl/ccip_pkg.sv -----
`default_nettype none
package ccip_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] CP_MIN = 21'h000001;
  localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

  // result status codes
  localparam logic [2:0] ST_INTERVAL   = 3'd0;
  localparam logic [2:0] ST_CLOSE      = 3'd1;
  localparam logic [2:0] ST_NO_BRACKET = 3'd2;
  localparam logic [2:0] ST_BAD_ESC    = 3'd3;
  localparam logic [2:0] ST_HEX_SHORT  = 3'd4;
  localparam logic [2:0] ST_RANGE      = 3'd5;
  localparam logic [2:0] ST_DIGITS     = 3'd6;
  localparam logic [2:0] ST_ORDER      = 3'd7;

  // shorthand classes
  localparam logic [2:0] SH_DIGIT     = 3'd0;
  localparam logic [2:0] SH_NOT_DIGIT = 3'd1;
  localparam logic [2:0] SH_SPACE     = 3'd2;
  localparam logic [2:0] SH_NOT_SPACE = 3'd3;
  localparam logic [2:0] SH_WORD      = 3'd4;
  localparam logic [2:0] SH_NOT_WORD  = 3'd5;

  typedef struct packed {
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
    logic [2:0]      status;
    logic            negated;
  } result_t;

  // one item's worth of results: optional held literal, optional '-',
  // then either one explicit result or a shorthand burst
  typedef struct packed {
    logic            held_en;
    logic            dash_en;
    logic            main_en;
    logic            sh_en;
    logic [2:0]      sh_sel;
    logic [CP_W-1:0] held;
    result_t         main;
  } job_t;

  function automatic logic [2:0] sh_count(input logic [2:0] sel);
    logic [2:0] n;
    case (sel)
      SH_DIGIT:     n = 3'd1;
      SH_NOT_DIGIT: n = 3'd2;
      SH_SPACE:     n = 3'd2;
      SH_NOT_SPACE: n = 3'd3;
      SH_WORD:      n = 3'd4;
      SH_NOT_WORD:  n = 3'd5;
      default:      n = 3'd0;
    endcase
    return n;
  endfunction

  // {lo, hi} of interval idx of a shorthand class
  function automatic logic [2*CP_W-1:0] sh_interval(input logic [2:0] sel,
                                                    input logic [2:0] idx);
    logic [2*CP_W-1:0] r;
    case ({sel, idx})
      {SH_DIGIT,     3'd0}: r = {21'h30, 21'h39};
      {SH_NOT_DIGIT, 3'd0}: r = {CP_MIN, 21'h2F};
      {SH_NOT_DIGIT, 3'd1}: r = {21'h3A, CP_MAX};
      {SH_SPACE,     3'd0}: r = {21'h09, 21'h0D};
      {SH_SPACE,     3'd1}: r = {21'h20, 21'h20};
      {SH_NOT_SPACE, 3'd0}: r = {CP_MIN, 21'h08};
      {SH_NOT_SPACE, 3'd1}: r = {21'h0E, 21'h1F};
      {SH_NOT_SPACE, 3'd2}: r = {21'h21, CP_MAX};
      {SH_WORD,      3'd0}: r = {21'h30, 21'h39};
      {SH_WORD,      3'd1}: r = {21'h41, 21'h5A};
      {SH_WORD,      3'd2}: r = {21'h5F, 21'h5F};
      {SH_WORD,      3'd3}: r = {21'h61, 21'h7A};
      {SH_NOT_WORD,  3'd0}: r = {CP_MIN, 21'h2F};
      {SH_NOT_WORD,  3'd1}: r = {21'h3A, 21'h40};
      {SH_NOT_WORD,  3'd2}: r = {21'h5B, 21'h5E};
      {SH_NOT_WORD,  3'd3}: r = {21'h60, 21'h60};
      {SH_NOT_WORD,  3'd4}: r = {21'h7B, CP_MAX};
      default:              r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ccip_front.sv -----
`default_nettype none
module ccip_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire logic                   q_full,
  input  wire logic [ccip_pkg::CP_W-1:0] code_point,
  input  wire logic                   end_of_text,
  output ccip_pkg::job_t              job,
  output logic                        job_push
);
  import ccip_pkg::*;

  localparam logic [2:0] PH_ITEM  = 3'd0;
  localparam logic [2:0] PH_HELD  = 3'd1;
  localparam logic [2:0] PH_DASH  = 3'd2;
  localparam logic [2:0] PH_ESC   = 3'd3;
  localparam logic [2:0] PH_UOPEN = 3'd4;
  localparam logic [2:0] PH_UFIX  = 3'd5;
  localparam logic [2:0] PH_UVAR0 = 3'd6;
  localparam logic [2:0] PH_UVAR  = 3'd7;

  localparam logic [CP_W-1:0] CH_DASH   = 21'h2D;
  localparam logic [CP_W-1:0] CH_BSLASH = 21'h5C;
  localparam logic [CP_W-1:0] CH_CARET  = 21'h5E;
  localparam logic [CP_W-1:0] CH_LBRACK = 21'h5B;
  localparam logic [CP_W-1:0] CH_RBRACK = 21'h5D;
  localparam logic [CP_W-1:0] CH_LBRACE = 21'h7B;
  localparam logic [CP_W-1:0] CH_RBRACE = 21'h7D;
  localparam logic [CP_W-1:0] CH_U      = 21'h75;
  localparam logic [CP_W-1:0] CH_N      = 21'h6E;
  localparam logic [CP_W-1:0] CH_F      = 21'h66;
  localparam logic [CP_W-1:0] CH_R      = 21'h72;
  localparam logic [CP_W-1:0] CH_T      = 21'h74;
  localparam logic [CP_W-1:0] CH_V      = 21'h76;
  localparam logic [CP_W-1:0] CH_A      = 21'h61;
  localparam logic [CP_W-1:0] CH_B      = 21'h62;
  localparam logic [CP_W-1:0] CH_E      = 21'h65;
  localparam logic [CP_W-1:0] CH_LC_D   = 21'h64;
  localparam logic [CP_W-1:0] CH_UC_D   = 21'h44;
  localparam logic [CP_W-1:0] CH_LC_S   = 21'h73;
  localparam logic [CP_W-1:0] CH_UC_S   = 21'h53;
  localparam logic [CP_W-1:0] CH_LC_W   = 21'h77;
  localparam logic [CP_W-1:0] CH_UC_W   = 21'h57;

  // {valid, value}
  function automatic logic [4:0] hex_value(input logic [CP_W-1:0] c);
    logic [4:0] r;
    if (c >= 21'h30 && c <= 21'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 21'h41 && c <= 21'h46) || (c >= 21'h61 && c <= 21'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

  logic [2:0]      phase, phase_next;
  logic [CP_W-1:0] held_low, held_low_next;
  logic            dash_seen, dash_seen_next;
  logic [23:0]     hex_accum, hex_accum_next;
  logic [2:0]      hex_cnt, hex_cnt_next;
  logic            negate, negate_next;
  logic            first, first_next;

  logic [4:0]      hv;
  logic [23:0]     acc_shift;
  logic            sh_hit;
  logic [2:0]      sh_sel;
  logic            fail_en, close_en, si_en, dv_en, fx_en;
  logic [2:0]      fail_code;
  logic [CP_W-1:0] dv_val;
  logic [23:0]     fx_val;
  logic            in_acc;

  assign hv        = hex_value(code_point);
  assign acc_shift = {hex_accum[19:0], hv[3:0]};
  assign in_acc    = push && !q_full;

  always_comb begin
    sh_hit = 1'b1;
    case (code_point)
      CH_LC_D: sh_sel = SH_DIGIT;
      CH_UC_D: sh_sel = SH_NOT_DIGIT;
      CH_LC_S: sh_sel = SH_SPACE;
      CH_UC_S: sh_sel = SH_NOT_SPACE;
      CH_LC_W: sh_sel = SH_WORD;
      CH_UC_W: sh_sel = SH_NOT_WORD;
      default: begin
        sh_hit = 1'b0;
        sh_sel = SH_DIGIT;
      end
    endcase
  end

  always_comb begin
    phase_next     = phase;
    held_low_next  = held_low;
    dash_seen_next = dash_seen;
    hex_accum_next = hex_accum;
    hex_cnt_next   = hex_cnt;
    negate_next    = negate;
    first_next     = first;
    job       = '0;
    fail_en   = 1'b0;
    fail_code = ST_NO_BRACKET;
    close_en  = 1'b0;
    si_en     = 1'b0;
    dv_en     = 1'b0;
    dv_val    = '0;
    fx_en     = 1'b0;
    fx_val    = '0;

    if (end_of_text) begin
      fail_en = 1'b1;
      if (phase == PH_ESC) begin
        fail_code = ST_BAD_ESC;
      end else if (phase >= PH_UOPEN) begin
        fail_code = ST_HEX_SHORT;
      end
    end else begin
      case (phase)
        PH_ITEM: si_en = 1'b1;
        PH_HELD: begin
          if (code_point == CH_DASH) begin
            dash_seen_next = 1'b1;
            phase_next     = PH_DASH;
          end else begin
            job.held_en = 1'b1;
            job.held    = held_low;
            phase_next  = PH_ITEM;
            si_en       = 1'b1;
          end
        end
        PH_DASH: begin
          if (code_point == CH_RBRACK) begin
            // trailing '-' is a literal
            job.held_en = 1'b1;
            job.held    = held_low;
            job.dash_en = 1'b1;
            close_en    = 1'b1;
          end else if (code_point == CH_BSLASH) begin
            phase_next = PH_ESC;
          end else begin
            dv_en  = 1'b1;
            dv_val = code_point;
          end
        end
        PH_ESC: begin
          case (code_point)
            CH_U: begin
              hex_accum_next = '0;
              hex_cnt_next   = '0;
              phase_next     = PH_UOPEN;
            end
            CH_N: begin dv_en = 1'b1; dv_val = 21'h0A; end
            CH_F: begin dv_en = 1'b1; dv_val = 21'h0C; end
            CH_R: begin dv_en = 1'b1; dv_val = 21'h0D; end
            CH_T: begin dv_en = 1'b1; dv_val = 21'h09; end
            CH_V: begin dv_en = 1'b1; dv_val = 21'h0B; end
            CH_A: begin dv_en = 1'b1; dv_val = 21'h07; end
            CH_B: begin dv_en = 1'b1; dv_val = 21'h08; end
            CH_E: begin dv_en = 1'b1; dv_val = 21'h1B; end
            CH_BSLASH, CH_CARET, CH_LBRACK, CH_RBRACK, CH_DASH: begin
              dv_en  = 1'b1;
              dv_val = code_point;
            end
            default: begin
              // a shorthand cannot end a range
              if (!dash_seen && sh_hit) begin
                job.sh_en  = 1'b1;
                job.sh_sel = sh_sel;
                phase_next = PH_ITEM;
              end else begin
                fail_en   = 1'b1;
                fail_code = ST_BAD_ESC;
              end
            end
          endcase
        end
        PH_UOPEN, PH_UFIX: begin
          if (phase == PH_UOPEN && code_point == CH_LBRACE) begin
            phase_next = PH_UVAR0;
          end else if (!hv[4]) begin
            fail_en   = 1'b1;
            fail_code = ST_HEX_SHORT;
          end else begin
            hex_accum_next = acc_shift;
            hex_cnt_next   = hex_cnt + 3'd1;
            phase_next     = PH_UFIX;
            if (hex_cnt >= 3'd5) begin
              fx_en  = 1'b1;
              fx_val = acc_shift;
            end
          end
        end
        PH_UVAR0: begin
          if (!hv[4]) begin
            fail_en   = 1'b1;
            fail_code = ST_HEX_SHORT;
          end else begin
            hex_accum_next = {20'd0, hv[3:0]};
            hex_cnt_next   = 3'd1;
            phase_next     = PH_UVAR;
          end
        end
        PH_UVAR: begin
          // count of 7 marks a seventh digit, reported on the next item
          if (hex_cnt >= 3'd7) begin
            fail_en   = 1'b1;
            fail_code = ST_DIGITS;
          end else if (code_point == CH_RBRACE) begin
            fx_en  = 1'b1;
            fx_val = hex_accum;
          end else if (!hv[4]) begin
            fail_en   = 1'b1;
            fail_code = ST_HEX_SHORT;
          end else if (hex_cnt >= 3'd6) begin
            hex_cnt_next = 3'd7;
          end else begin
            hex_accum_next = acc_shift;
            hex_cnt_next   = hex_cnt + 3'd1;
          end
        end
        default: si_en = 1'b1;
      endcase
    end

    if (fx_en) begin
      if (fx_val < 24'(CP_MIN) || fx_val > 24'(CP_MAX)) begin
        fail_en   = 1'b1;
        fail_code = ST_RANGE;
      end else begin
        dv_en  = 1'b1;
        dv_val = fx_val[CP_W-1:0];
      end
    end

    if (dv_en) begin
      if (dash_seen) begin
        if (dv_val < held_low) begin
          fail_en   = 1'b1;
          fail_code = ST_ORDER;
        end else begin
          job.main_en    = 1'b1;
          job.main.lo    = held_low;
          job.main.hi    = dv_val;
          dash_seen_next = 1'b0;
          phase_next     = PH_ITEM;
        end
      end else begin
        held_low_next = dv_val;
        phase_next    = PH_HELD;
      end
    end

    if (si_en) begin
      if (code_point == CH_RBRACK) begin
        close_en = 1'b1;
      end else if (code_point == CH_CARET && first) begin
        negate_next = 1'b1;
        first_next  = 1'b0;
      end else begin
        first_next = 1'b0;
        if (code_point == CH_BSLASH) begin
          dash_seen_next = 1'b0;
          phase_next     = PH_ESC;
        end else begin
          held_low_next = code_point;
          phase_next    = PH_HELD;
        end
      end
    end

    if (close_en || fail_en) begin
      phase_next     = PH_ITEM;
      held_low_next  = '0;
      dash_seen_next = 1'b0;
      hex_accum_next = '0;
      hex_cnt_next   = '0;
      negate_next    = 1'b0;
      first_next     = 1'b1;
    end

    if (close_en) begin
      job.main_en      = 1'b1;
      job.main.lo      = '0;
      job.main.hi      = '0;
      job.main.status  = ST_CLOSE;
      job.main.negated = negate;
    end

    if (fail_en) begin
      job             = '0;
      job.main_en     = 1'b1;
      job.main.status = fail_code;
    end
  end

  assign job_push = in_acc && (job.held_en || job.dash_en || job.main_en || job.sh_en);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_ITEM;
      held_low  <= '0;
      dash_seen <= 1'b0;
      hex_accum <= '0;
      hex_cnt   <= '0;
      negate    <= 1'b0;
      first     <= 1'b1;
    end else if (in_acc) begin
      phase     <= phase_next;
      held_low  <= held_low_next;
      dash_seen <= dash_seen_next;
      hex_accum <= hex_accum_next;
      hex_cnt   <= hex_cnt_next;
      negate    <= negate_next;
      first     <= first_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ccip_jobq.sv -----
`default_nettype none
module ccip_jobq #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire ccip_pkg::job_t wr_job,
  output logic                full,
  input  wire logic           rd_en,
  output ccip_pkg::job_t      rd_job,
  output logic                empty
);
  import ccip_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t            slots [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;
  logic            do_wr, do_rd;

  assign full   = (count == (AW+1)'(DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ccip_back.sv -----
`default_nettype none
module ccip_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ccip_pkg::job_t            job,
  input  wire logic                      job_valid,
  output logic                           job_pop,
  input  wire logic                      pop,
  output logic                           empty,
  output logic [ccip_pkg::CP_W-1:0]      interval_low,
  output logic [ccip_pkg::CP_W-1:0]      interval_high,
  output logic [2:0]                     status,
  output logic                           negated,
  output logic                           last
);
  import ccip_pkg::*;

  localparam logic [CP_W-1:0] CH_DASH = 21'h2D;

  logic [2:0]        step;
  logic [2:0]        pre, total, m;
  logic [2*CP_W-1:0] sh_pair;
  result_t           entry;
  logic              entry_last;
  logic              out_valid;
  logic              load;

  assign pre   = {2'd0, job.held_en} + {2'd0, job.dash_en};
  assign total = pre + {2'd0, job.main_en} + (job.sh_en ? sh_count(job.sh_sel) : 3'd0);
  assign m     = step - pre;
  assign sh_pair = sh_interval(job.sh_sel, m);

  always_comb begin
    entry = '0;
    if (step == 3'd0 && job.held_en) begin
      entry.lo = job.held;
      entry.hi = job.held;
    end else if (step < pre) begin
      entry.lo = CH_DASH;
      entry.hi = CH_DASH;
    end else if (job.main_en) begin
      entry = job.main;
    end else begin
      entry.lo = sh_pair[2*CP_W-1:CP_W];
      entry.hi = sh_pair[CP_W-1:0];
    end
  end

  assign entry_last = (step == total - 3'd1);
  assign load       = job_valid && (!out_valid || pop);
  assign job_pop    = load && entry_last;
  assign empty      = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= entry_last ? 3'd0 : step + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      interval_low  <= entry.lo;
      interval_high <= entry.hi;
      status        <= entry.status;
      negated       <= entry.negated;
      last          <= entry_last;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/char_class_interval_parser.sv -----
`default_nettype none
// Bracket-expression parser: takes one code point per cycle (text after the
// opening '[') and returns code point intervals, a close result carrying the
// negation flag, or an error code. The front end parses an item in the cycle
// it is taken and accepts one every cycle while the job queue has room; an
// item that gives results becomes one job in a JOB_DEPTH-entry queue. The back
// end turns a job into its results at one per cycle while the output is empty
// or popped; a job of up to five results (for \W) holds it until all are
// loaded. The queue absorbs such bursts; full rises only once it fills. Jobs
// are queued as their items are taken, then fed to the output, a single
// register that reloads in the same cycle it is popped.
module char_class_interval_parser #(
  parameter int unsigned JOB_DEPTH = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [ccip_pkg::CP_W-1:0] code_point,
  input  wire logic                      end_of_text,
  input  wire logic                      pop,
  output logic                           empty,
  output logic [ccip_pkg::CP_W-1:0]      interval_low,
  output logic [ccip_pkg::CP_W-1:0]      interval_high,
  output logic [2:0]                     status,
  output logic                           negated,
  output logic                           last
);
  import ccip_pkg::*;

  job_t wr_job, rd_job;
  logic job_push, job_pop, q_empty;

  ccip_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .q_full      (full),
    .code_point  (code_point),
    .end_of_text (end_of_text),
    .job         (wr_job),
    .job_push    (job_push)
  );

  ccip_jobq #(
    .DEPTH (JOB_DEPTH)
  ) u_jobq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (wr_job),
    .full   (full),
    .rd_en  (job_pop),
    .rd_job (rd_job),
    .empty  (q_empty)
  );

  ccip_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job           (rd_job),
    .job_valid     (!q_empty),
    .job_pop       (job_pop),
    .pop           (pop),
    .empty         (empty),
    .interval_low  (interval_low),
    .interval_high (interval_high),
    .status        (status),
    .negated       (negated),
    .last          (last)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/ccip_checker.sv -----
`default_nettype none
module ccip_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      pop,
  input wire logic                      empty,
  input wire logic [ccip_pkg::CP_W-1:0] interval_low,
  input wire logic [ccip_pkg::CP_W-1:0] interval_high,
  input wire logic [2:0]                status,
  input wire logic                      negated,
  input wire logic                      last
);
  import ccip_pkg::*;

  // close and error results carry no bounds
  a_no_bounds: assert property (@(posedge clk) disable iff (rst)
    !empty && status != ST_INTERVAL |-> interval_low == '0 && interval_high == '0)
    else $error("non-interval result with bounds");

  a_neg_on_close: assert property (@(posedge clk) disable iff (rst)
    !empty && negated |-> status == ST_CLOSE)
    else $error("negated flag outside a close result");

  a_ordered: assert property (@(posedge clk) disable iff (rst)
    !empty && status == ST_INTERVAL |-> interval_low <= interval_high)
    else $error("interval bounds out of order");

  // nothing may follow a close or an error for the same item
  a_final: assert property (@(posedge clk) disable iff (rst)
    !empty && status != ST_INTERVAL |-> last)
    else $error("close or error result not marked last");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(interval_low) && $stable(interval_high)
      && $stable(status) && $stable(negated) && $stable(last))
    else $error("waiting item changed");

endmodule

bind char_class_interval_parser ccip_checker u_ccip_checker (
  .clk           (clk),
  .rst           (rst),
  .pop           (pop),
  .empty         (empty),
  .interval_low  (interval_low),
  .interval_high (interval_high),
  .status        (status),
  .negated       (negated),
  .last          (last)
);
`default_nettype wire
